[rtl/stgs_pkg.sv]
// Shared constants, codes and helper tables for the sparse tiled grid store.
package stgs_pkg;

    localparam int CMD_BITS       = 2;
    localparam int COORD_BITS     = 8;
    localparam int VALUE_BITS     = 32;
    localparam int STATUS_BITS    = 2;
    localparam int CNT_BITS       = 9;
    localparam int SIDE_BITS      = 9;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COORD_SPAN     = 1 << COORD_BITS;

    localparam int MAX_SIDE       = 256;
    localparam int DEF_TILE_SIZE  = 16;
    localparam int DEF_POOL_TILES = 16;

    localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(256);

    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_BOUNDS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_UPDATE
    } stgs_state_t;

    typedef enum logic [1:0] {
        POOL_NONE,
        POOL_TAKE,
        POOL_GIVE
    } pool_op_t;

    typedef logic [COORD_BITS-1:0] coord_tab_t [COORD_SPAN];

    // Coordinate -> tile index, built by counting so no divider is needed.
    function automatic coord_tab_t build_quot(input int ts);
        coord_tab_t tab;
        int q;
        int r;
        q = 0;
        r = 0;
        for (int i = 0; i < COORD_SPAN; i++) begin
            tab[i] = COORD_BITS'(q);
            r++;
            if (r == ts) begin
                r = 0;
                q++;
            end
        end
        return tab;
    endfunction

    // Coordinate -> offset inside its tile.
    function automatic coord_tab_t build_rem(input int ts);
        coord_tab_t tab;
        int r;
        r = 0;
        for (int i = 0; i < COORD_SPAN; i++) begin
            tab[i] = COORD_BITS'(r);
            r++;
            if (r == ts) begin
                r = 0;
            end
        end
        return tab;
    endfunction

endpackage

[rtl/stgs_req_if.sv]
// Request channel: command, cell position and write value.
interface stgs_req_if;
    import stgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   command;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [VALUE_BITS-1:0] write_value;

    modport source (output valid, command, cell_x, cell_y, write_value, input ready);
    modport sink   (input valid, command, cell_x, cell_y, write_value, output ready);
endinterface

[rtl/stgs_rsp_if.sv]
// Response channel: cell value, flags, status and tile occupancy.
interface stgs_rsp_if;
    import stgs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  read_value;
    logic                   cell_active;
    logic [STATUS_BITS-1:0] status;
    logic                   tile_present;
    logic [CNT_BITS-1:0]    tile_active_cells;

    modport source (output valid, read_value, cell_active, status, tile_present,
                    tile_active_cells, input ready);
    modport sink   (input valid, read_value, cell_active, status, tile_present,
                    tile_active_cells, output ready);
endinterface

[rtl/stgs_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module stgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/stgs_pool.sv]
// Tile slot pool: free flags and a two-level lowest-free-slot search.
module stgs_pool #(
    parameter int POOL_TILES = stgs_pkg::DEF_POOL_TILES,
    localparam int SB = (POOL_TILES > 1) ? $clog2(POOL_TILES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stgs_pkg::pool_op_t op,
    input  logic [SB-1:0]     op_slot,
    output logic              free_any,
    output logic [SB-1:0]     free_slot
);
    import stgs_pkg::*;

    localparam int GRP = 16;
    localparam int GB  = 4;
    localparam int NG  = (POOL_TILES + GRP - 1) / GRP;
    localparam int NGB = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD = NG * GRP;

    logic [POOL_TILES-1:0] free_reg;
    logic [POOL_TILES-1:0] free_next;
    logic [PAD-1:0]        free_pad;
    logic [NG-1:0]         grp_any_reg;
    logic [NG-1:0]         grp_any_next;
    logic [GB-1:0]         grp_idx_reg [NG];
    logic [GB-1:0]         grp_idx_next [NG];
    logic [NGB-1:0]        grp_sel;
    logic [NGB+GB-1:0]     slot_full;

    assign free_pad = PAD'(free_reg);

    always_comb
    begin
        free_next = free_reg;
        case (op)
            POOL_TAKE: free_next[op_slot] = 1'b0;
            POOL_GIVE: free_next[op_slot] = 1'b1;
            default:   free_next = free_reg;
        endcase
    end

    // First level: per group of 16, registered.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |free_pad[g*GRP +: GRP];
            grp_idx_next[g] = '0;
            for (int j = GRP - 1; j >= 0; j--)
            begin
                if (free_pad[g*GRP + j])
                begin
                    grp_idx_next[g] = GB'(j);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg    <= '1;
            grp_any_reg <= '0;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
        end
        else
        begin
            free_reg    <= free_next;
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    // Second level: lowest group with a free slot.
    always_comb
    begin
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                grp_sel = NGB'(g);
            end
        end
    end

    assign slot_full = {grp_sel, grp_idx_reg[grp_sel]};
    assign free_slot = slot_full[SB-1:0];
    assign free_any  = |grp_any_reg;
endmodule

[rtl/sparse_tiled_grid_store.sv]
// Top level of the sparse tiled grid store: sequencer, memories and slot pool.
//
// Usage: requests arrive on req (command, cell_x, cell_y, write_value) and
// each produces exactly one beat on rsp (read_value, cell_active, status,
// tile_present, tile_active_cells). Both channels are valid/ready; a beat
// moves on a clock edge with valid and ready high. grid_width and
// grid_height are set through cfg_we/cfg_index/cfg_wdata while idle.
// Sequence: a request is taken in S_IDLE while the tile map is read, the
// slot's active row, count and value are read in S_LOOK, and the update is
// written and the response registered at the end of S_UPDATE. Only one
// request is in work at a time, so a new request is taken only once the
// last one has been written back; the sequence follows the two dependent
// memory reads (tile map, then slot data) and the write back.
// Reset: the pool comes up all free and a clearing pass sweeps the tile map
// and active-bit memories; req.ready stays low until it ends.
// Stalls: the response register holds while rsp.ready is low; one further
// request may be taken meanwhile and waits in its update cycle for the
// register to drain.
module sparse_tiled_grid_store #(
    parameter int TILE_SIZE  = stgs_pkg::DEF_TILE_SIZE,
    parameter int POOL_TILES = stgs_pkg::DEF_POOL_TILES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    stgs_req_if.sink                             req,
    stgs_rsp_if.source                           rsp,
    input  logic                                 cfg_we,
    input  logic [stgs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [stgs_pkg::SIDE_BITS-1:0]       cfg_wdata
);
    import stgs_pkg::*;

    localparam int TPS      = (MAX_SIDE + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TB       = $clog2(TPS);
    localparam int LB       = $clog2(TILE_SIZE);
    localparam int SB       = (POOL_TILES > 1) ? $clog2(POOL_TILES) : 1;
    localparam int MAP_AW   = 2 * TB;
    localparam int MAP_W    = SB + 1;
    localparam int ROW_AW   = SB + LB;
    localparam int VAL_AW   = SB + 2 * LB;
    localparam int CLR_BITS = (MAP_AW > ROW_AW) ? MAP_AW : ROW_AW;

    localparam coord_tab_t QUOT_TAB = build_quot(TILE_SIZE);
    localparam coord_tab_t REM_TAB  = build_rem(TILE_SIZE);

    // Control state
    stgs_state_t           state_reg, state_next;
    logic [CLR_BITS-1:0]   clr_reg, clr_next;
    logic [SIDE_BITS-1:0]  grid_width_reg, grid_height_reg;

    // Request held for the duration of the access
    logic [CMD_BITS-1:0]   cmd_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic                  oob_reg;
    logic [MAP_AW-1:0]     tile_reg;
    logic [LB-1:0]         lx_reg, ly_reg;
    logic                  hit_reg;
    logic [SB-1:0]         slot_reg;

    // Response register
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [VALUE_BITS-1:0]  rd_value_reg, rd_value_next;
    logic                   active_reg, active_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   present_reg, present_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    // Handshake and sequencing strobes
    logic accept;
    logic fire;
    logic clr_done;

    // Request decode
    logic [TB-1:0] tx_in, ty_in;
    logic [LB-1:0] lx_in, ly_in;
    logic          oob_in;

    // Memory ports
    logic                  map_we, map_re;
    logic [MAP_AW-1:0]     map_waddr, map_raddr;
    logic [MAP_W-1:0]      map_wdata, map_rdata;
    logic                  row_we, slot_re;
    logic [ROW_AW-1:0]     row_waddr, row_raddr;
    logic [TILE_SIZE-1:0]  row_wdata, row_rdata;
    logic                  cnt_we;
    logic [SB-1:0]         cnt_waddr, cnt_raddr;
    logic [CNT_BITS-1:0]   cnt_wdata, cnt_rdata;
    logic                  val_we;
    logic [VAL_AW-1:0]     val_waddr, val_raddr;
    logic [VALUE_BITS-1:0] val_rdata;

    // Update datapath
    pool_op_t              pool_op;
    logic                  pool_any;
    logic [SB-1:0]         pool_slot;
    logic [SB-1:0]         slot_sel;
    logic [TILE_SIZE-1:0]  bit_mask;
    logic                  cur_active;
    logic [CNT_BITS-1:0]   cnt_inc, cnt_dec;
    logic                  upd_map_we, upd_row_we, upd_cnt_we, upd_val_we;
    logic [MAP_W-1:0]      upd_map_data;
    logic [TILE_SIZE-1:0]  upd_row_data;
    logic [CNT_BITS-1:0]   upd_cnt_data;

    assign accept   = req.valid && req.ready;
    assign fire     = (state_reg == S_UPDATE) && (!rsp_valid_reg || rsp.ready);
    assign clr_done = (clr_reg == '1);

    // Coordinate split via constant tables; bounds against the registers.
    // Coordinates never exceed 255, so comparing against the register alone
    // matches the clamp to the largest side.
    assign tx_in  = QUOT_TAB[req.cell_x][TB-1:0];
    assign ty_in  = QUOT_TAB[req.cell_y][TB-1:0];
    assign lx_in  = REM_TAB[req.cell_x][LB-1:0];
    assign ly_in  = REM_TAB[req.cell_y][LB-1:0];
    assign oob_in = ({1'b0, req.cell_x} >= grid_width_reg) ||
                    ({1'b0, req.cell_y} >= grid_height_reg);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        req.ready  = 1'b0;
        map_re     = 1'b0;
        slot_re    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                map_re    = req.valid;
                if (req.valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                slot_re    = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= SIDE_RESET;
            grid_height_reg <= SIDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // ---------------- request hold ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.command;
            wval_reg <= req.write_value;
            oob_reg  <= oob_in;
            tile_reg <= {ty_in, tx_in};
            lx_reg   <= lx_in;
            ly_reg   <= ly_in;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg  <= map_rdata[MAP_W-1];
            slot_reg <= map_rdata[SB-1:0];
        end
    end

    // ---------------- update ----------------
    assign slot_sel   = hit_reg ? slot_reg : pool_slot;
    assign bit_mask   = TILE_SIZE'(1) << lx_reg;
    assign cur_active = hit_reg && row_rdata[lx_reg];
    assign cnt_inc    = cnt_rdata + 1'b1;
    assign cnt_dec    = cnt_rdata - 1'b1;

    always_comb
    begin
        upd_map_we    = 1'b0;
        upd_row_we    = 1'b0;
        upd_cnt_we    = 1'b0;
        upd_val_we    = 1'b0;
        upd_map_data  = '0;
        upd_row_data  = row_rdata;
        upd_cnt_data  = cnt_rdata;
        pool_op       = POOL_NONE;
        rd_value_next = '0;
        active_next   = 1'b0;
        status_next   = STATUS_OK;
        present_next  = 1'b0;
        count_next    = '0;

        if (oob_reg)
        begin
            status_next = STATUS_BOUNDS;
        end
        else if (!hit_reg)
        begin
            if (cmd_reg == CMD_WRITE)
            begin
                if (!pool_any)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    // New tile: freed slots always hold an all-zero row set.
                    pool_op       = POOL_TAKE;
                    upd_map_we    = 1'b1;
                    upd_map_data  = {1'b1, pool_slot};
                    upd_row_we    = 1'b1;
                    upd_row_data  = bit_mask;
                    upd_cnt_we    = 1'b1;
                    upd_cnt_data  = CNT_BITS'(1);
                    upd_val_we    = 1'b1;
                    rd_value_next = wval_reg;
                    active_next   = 1'b1;
                    present_next  = 1'b1;
                    count_next    = CNT_BITS'(1);
                end
            end
        end
        else if (cmd_reg == CMD_WRITE)
        begin
            upd_val_we    = 1'b1;
            rd_value_next = wval_reg;
            active_next   = 1'b1;
            present_next  = 1'b1;
            count_next    = cnt_rdata;
            if (!cur_active)
            begin
                upd_row_we   = 1'b1;
                upd_row_data = row_rdata | bit_mask;
                upd_cnt_we   = 1'b1;
                upd_cnt_data = cnt_inc;
                count_next   = cnt_inc;
            end
        end
        else if ((cmd_reg == CMD_CLEAR) && cur_active)
        begin
            upd_row_we   = 1'b1;
            upd_row_data = row_rdata & ~bit_mask;
            upd_cnt_we   = 1'b1;
            upd_cnt_data = cnt_dec;
            if (cnt_dec == '0)
            begin
                // Last active cell gone: release the tile and its slot.
                upd_map_we = 1'b1;
                pool_op    = POOL_GIVE;
            end
            else
            begin
                present_next = 1'b1;
                count_next   = cnt_dec;
            end
        end
        else
        begin
            // Read, unused command code, or clear of an inactive cell.
            rd_value_next = cur_active ? val_rdata : '0;
            active_next   = cur_active;
            present_next  = 1'b1;
            count_next    = cnt_rdata;
        end

        if (!fire)
        begin
            upd_map_we = 1'b0;
            upd_row_we = 1'b0;
            upd_cnt_we = 1'b0;
            upd_val_we = 1'b0;
            pool_op    = POOL_NONE;
        end
    end

    // ---------------- memory port muxing ----------------
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_reg[MAP_AW-1:0];
            map_wdata = '0;
            row_we    = 1'b1;
            row_waddr = clr_reg[ROW_AW-1:0];
            row_wdata = '0;
        end
        else
        begin
            map_we    = upd_map_we;
            map_waddr = tile_reg;
            map_wdata = upd_map_data;
            row_we    = upd_row_we;
            row_waddr = {slot_sel, ly_reg};
            row_wdata = upd_row_data;
        end
    end

    assign map_raddr = {ty_in, tx_in};
    assign row_raddr = {map_rdata[SB-1:0], ly_reg};
    assign cnt_raddr = map_rdata[SB-1:0];
    assign val_raddr = {map_rdata[SB-1:0], ly_reg, lx_reg};
    assign cnt_we    = upd_cnt_we;
    assign cnt_waddr = slot_sel;
    assign cnt_wdata = upd_cnt_data;
    assign val_we    = upd_val_we;
    assign val_waddr = {slot_sel, ly_reg, lx_reg};

    stgs_ram #(.WIDTH(MAP_W), .DEPTH(1 << MAP_AW)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    stgs_ram #(.WIDTH(TILE_SIZE), .DEPTH(1 << ROW_AW)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (slot_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    stgs_ram #(.WIDTH(CNT_BITS), .DEPTH(1 << SB)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (slot_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    stgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << VAL_AW)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (wval_reg),
        .re    (slot_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    stgs_pool #(.POOL_TILES(POOL_TILES)) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (pool_op),
        .op_slot   (slot_sel),
        .free_any  (pool_any),
        .free_slot (pool_slot)
    );

    // ---------------- response register ----------------
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_value_reg <= rd_value_next;
            active_reg   <= active_next;
            status_reg   <= status_next;
            present_reg  <= present_next;
            count_reg    <= count_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.read_value        = rd_value_reg;
    assign rsp.cell_active       = active_reg;
    assign rsp.status            = status_reg;
    assign rsp.tile_present      = present_reg;
    assign rsp.tile_active_cells = count_reg;
endmodule

[test/sparse_tiled_grid_store_tb.sv]
// Self-checking testbench for the sparse tiled grid store: directed and random cell accesses.
module sparse_tiled_grid_store_tb;
    import stgs_pkg::*;

    // Geometry of the default build; the scoreboard mirrors it.
    localparam int TILE         = DEF_TILE_SIZE;
    localparam int POOL         = DEF_POOL_TILES;
    localparam int TILES_ACROSS = MAX_SIDE / TILE;
    localparam int TILE_TOTAL   = TILES_ACROSS * TILES_ACROSS;
    localparam int CELLS        = TILE * TILE;

    localparam int HOT_TILES    = 20;    // more tiles than slots, so the pool runs dry
    localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either channel
    localparam int REPORT_LIMIT = 10;

    // Command code 3 is unused and must behave like a read.
    localparam logic [CMD_BITS-1:0]       CMD_SPARE    = 2'd3;
    // Register indexes past the two real registers; writes there are dropped.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic [COORD_BITS-1:0] cell_x;
        logic [COORD_BITS-1:0] cell_y;
        logic [VALUE_BITS-1:0] write_value;
    } grid_access_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  read_value;
        logic                   cell_active;
        logic [STATUS_BITS-1:0] status;
        logic                   tile_present;
        logic [CNT_BITS-1:0]    tile_active_cells;
    } cell_report_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [SIDE_BITS-1:0]      cfg_wdata;

    stgs_req_if req_ch ();
    stgs_rsp_if rsp_ch ();

    sparse_tiled_grid_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the grid: bounds, tile map, slot pool, active masks,
    // per-slot counts and stored values.
    // ------------------------------------------------------------------
    logic [SIDE_BITS-1:0]  grid_w;
    logic [SIDE_BITS-1:0]  grid_h;
    bit                    tile_used   [TILE_TOTAL];
    int                    tile_slot   [TILE_TOTAL];
    bit                    slot_taken  [POOL];
    logic [TILE-1:0]       slot_rows   [POOL][TILE];
    int                    slot_count  [POOL];
    logic [VALUE_BITS-1:0] slot_values [POOL][CELLS];

    cell_report_t pending_reports [$];   // expected response beats, oldest first
    int           errors      = 0;
    int           quiet_cycles = 0;

    // Traffic knobs, percent per cycle.
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;                   // long receiver hold-off, in cycles

    int hot_tile [HOT_TILES];

    // Apply one access to the shadow grid and return the response it must give.
    function automatic cell_report_t apply_access(input grid_access_t a);
        cell_report_t rep;
        int           x_lim;
        int           y_lim;
        int           tid;
        int           lx;
        int           ly;
        int           slot;
        logic         lit;
        rep   = '0;
        x_lim = (grid_w > MAX_SIDE) ? MAX_SIDE : grid_w;
        y_lim = (grid_h > MAX_SIDE) ? MAX_SIDE : grid_h;
        if (a.cell_x >= x_lim || a.cell_y >= y_lim) begin
            rep.status = STATUS_BOUNDS;
            return rep;
        end
        tid        = (a.cell_y / TILE) * TILES_ACROSS + a.cell_x / TILE;
        lx         = a.cell_x % TILE;
        ly         = a.cell_y % TILE;
        rep.status = STATUS_OK;
        if (!tile_used[tid]) begin
            // only a write brings a tile in; everything else sees an empty cell
            if (a.command != CMD_WRITE)
                return rep;
            slot = -1;
            for (int s = POOL - 1; s >= 0; s--)
                if (!slot_taken[s])
                    slot = s;
            if (slot < 0) begin
                rep.status = STATUS_FULL;
                return rep;
            end
            slot_taken[slot] = 1'b1;
            tile_used[tid]   = 1'b1;
            tile_slot[tid]   = slot;
            for (int r = 0; r < TILE; r++)
                slot_rows[slot][r] = '0;
            slot_count[slot] = 0;
        end
        slot = tile_slot[tid];
        lit  = slot_rows[slot][ly][lx];
        if (a.command == CMD_WRITE) begin
            slot_values[slot][ly * TILE + lx] = a.write_value;
            if (!lit) begin
                slot_rows[slot][ly][lx] = 1'b1;
                slot_count[slot]++;
                lit = 1'b1;
            end
        end else if (a.command == CMD_CLEAR && lit) begin
            slot_rows[slot][ly][lx] = 1'b0;
            slot_count[slot]--;
            lit = 1'b0;
            if (slot_count[slot] == 0) begin
                // last cell gone: tile drops out and its slot goes back
                tile_used[tid]   = 1'b0;
                slot_taken[slot] = 1'b0;
                return rep;
            end
        end
        rep.read_value        = lit ? slot_values[slot][ly * TILE + lx] : '0;
        rep.cell_active       = lit;
        rep.tile_present      = 1'b1;
        rep.tile_active_cells = CNT_BITS'(slot_count[slot]);
        return rep;
    endfunction

    function automatic grid_access_t make_access(input logic [CMD_BITS-1:0] cmd,
                                                 input int x, input int y,
                                                 input logic [VALUE_BITS-1:0] value);
        grid_access_t a;
        a.command     = cmd;
        a.cell_x      = COORD_BITS'(x);
        a.cell_y      = COORD_BITS'(y);
        a.write_value = value;
        return a;
    endfunction

    // Mostly traffic on a few cells of the hot tiles so writes and clears
    // meet; the rest is anything at all.
    function automatic grid_access_t random_access();
        grid_access_t a;
        int           t;
        int           pick;
        a.write_value = $urandom;
        pick = $urandom_range(9);
        if (pick == 0)
            a.write_value = '0;
        else if (pick == 1)
            a.write_value = '1;
        if ($urandom_range(99) < 75) begin
            t        = hot_tile[$urandom_range(HOT_TILES - 1)];
            a.cell_x = COORD_BITS'((t % TILES_ACROSS) * TILE + $urandom_range(3));
            a.cell_y = COORD_BITS'((t / TILES_ACROSS) * TILE + $urandom_range(1));
            pick     = $urandom_range(99);
            a.command = (pick < 42) ? CMD_WRITE :
                        (pick < 84) ? CMD_CLEAR :
                        (pick < 96) ? CMD_READ  : CMD_SPARE;
        end else begin
            a.command = CMD_BITS'($urandom_range(3));
            a.cell_x  = COORD_BITS'($urandom_range(255));
            a.cell_y  = COORD_BITS'($urandom_range(255));
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Optional idle cycles first, then hold the beat until
    // the block takes it. valid stays high between back-to-back beats.
    // ------------------------------------------------------------------
    task automatic send_access(input grid_access_t a);
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= a.command;
        req_ch.cell_x      <= a.cell_x;
        req_ch.cell_y      <= a.cell_y;
        req_ch.write_value <= a.write_value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_reports.push_back(apply_access(a));
    endtask

    // Stop offering and wait until every response has been seen.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Register write; caller lowers cfg_we after the last one.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SIDE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == REG_GRID_WIDTH)
            grid_w = value;
        else if (idx == REG_GRID_HEIGHT)
            grid_h = value;
    endtask

    task automatic configure(input logic [SIDE_BITS-1:0] w, input logic [SIDE_BITS-1:0] h);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // Pick a slot at random and, if it is occupied, clear its active cells in shuffled
    // order while the item budget lasts, so the tile is released and the pool recovers.
    task automatic sweep_tile(inout int left);
        grid_access_t batch [$];
        int           slot;
        int           tid;
        slot = $urandom_range(POOL - 1);
        if (!slot_taken[slot])
            return;
        tid = 0;
        for (int t = 0; t < TILE_TOTAL; t++)
            if (tile_used[t] && tile_slot[t] == slot)
                tid = t;
        for (int ly = 0; ly < TILE; ly++)
            for (int lx = 0; lx < TILE; lx++)
                if (slot_rows[slot][ly][lx])
                    batch.push_back(make_access(CMD_CLEAR,
                                                (tid % TILES_ACROSS) * TILE + lx,
                                                (tid / TILES_ACROSS) * TILE + ly,
                                                $urandom));
        batch.shuffle();
        foreach (batch[i]) begin
            if (left > 0) begin
                send_access(batch[i]);
                left--;
            end
        end
    endtask

    task automatic run_random(input int items, input int idle, input int stall,
                              input logic [SIDE_BITS-1:0] w, input logic [SIDE_BITS-1:0] h);
        int left;
        idle_pct  = idle;
        stall_pct = stall;
        configure(w, h);
        foreach (hot_tile[i])
            hot_tile[i] = $urandom_range(TILE_TOTAL - 1);
        left = items;
        while (left > 0) begin
            if ($urandom_range(99) < 4)
                sweep_tile(left);
            else begin
                send_access(random_access());
                left--;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset bounds: absent tiles, first write, rewrite, spare command,
    // clear of an inactive cell, release of a tile by its last clear.
    task automatic test_basic_access();
        send_access(make_access(CMD_READ,  10,  20, 32'h0));
        send_access(make_access(CMD_CLEAR, 10,  20, 32'h1234_5678));
        send_access(make_access(CMD_WRITE,  0,   0, '1));
        send_access(make_access(CMD_WRITE, 255, 255, '0));
        send_access(make_access(CMD_READ,   0,   0, 32'h0));
        send_access(make_access(CMD_WRITE,  0,   0, 32'h5555_AAAA));
        send_access(make_access(CMD_WRITE,  1,   0, 32'h0F0F_0F0F));
        send_access(make_access(CMD_CLEAR,  2,   0, 32'h0));
        send_access(make_access(CMD_SPARE,  1,   0, 32'h0));
        send_access(make_access(CMD_CLEAR,  0,   0, 32'h0));
        send_access(make_access(CMD_CLEAR,  1,   0, 32'h0));
        send_access(make_access(CMD_READ,   1,   0, 32'h0));
        send_access(make_access(CMD_CLEAR, 255, 255, 32'h0));
        settle();
    endtask

    // Bounds at the extremes, zero included, and writes to unused indexes.
    task automatic test_bounds();
        configure(9'd1, 9'd1);
        send_access(make_access(CMD_READ,  0, 0, 32'h0));
        send_access(make_access(CMD_WRITE, 1, 0, 32'hDEAD_BEEF));
        send_access(make_access(CMD_WRITE, 0, 1, 32'hDEAD_BEEF));
        settle();
        configure(9'd0, 9'd256);
        send_access(make_access(CMD_READ, 0, 0, 32'h0));
        settle();
        configure(9'd256, 9'd0);
        send_access(make_access(CMD_CLEAR, 0, 0, 32'h0));
        settle();
        write_reg(REG_SPARE_LO, 9'd0);
        write_reg(REG_SPARE_HI, 9'd3);
        configure(9'd511, 9'd511);
        send_access(make_access(CMD_WRITE, 255, 255, 32'h8000_0001));
        send_access(make_access(CMD_READ,  255, 255, 32'h0));
        settle();
    endtask

    // Take every slot, overflow, free one and take it back.
    task automatic test_pool_exhaustion();
        for (int i = 0; i < POOL; i++)
            send_access(make_access(CMD_WRITE, i * TILE, TILE, $urandom));
        send_access(make_access(CMD_WRITE, 0, 2 * TILE, 32'hCAFE_F00D));
        send_access(make_access(CMD_READ,  0, 2 * TILE, 32'h0));
        send_access(make_access(CMD_CLEAR, TILE, TILE, 32'h0));
        send_access(make_access(CMD_WRITE, 0, 2 * TILE, 32'hCAFE_F00D));
        send_access(make_access(CMD_READ,  0, 2 * TILE, 32'h0));
        settle();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering;
    // the block fills and must push back on its request side.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 12; i++)
            send_access(random_access());
        settle();
    endtask

    task automatic test_random_no_idle();
        run_random(330, 0, 0, 9'd256, 9'd256);
    endtask

    task automatic test_random_sender_idle();
        run_random(330, 76, 0, 9'd511, 9'd300);
    endtask

    task automatic test_random_receiver_stall();
        run_random(330, 0, 76, 9'd200, 9'd137);
    endtask

    task automatic test_random_both_idle();
        run_random(330, 16, 16, 9'd256, 9'd256);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_READ;
        req_ch.cell_x      <= '0;
        req_ch.cell_y      <= '0;
        req_ch.write_value <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_GRID_WIDTH;
        cfg_wdata          <= '0;
        grid_w = SIDE_RESET;
        grid_h = SIDE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // ready stays low through the clearing pass; send_access waits for it
        test_basic_access();
        test_bounds();
        test_pool_exhaustion();
        test_random_no_idle();
        test_backpressure();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        // let anything stray show up before the verdict
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Response side: long hold-off when asked, random stalls otherwise.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check each response beat against the oldest expectation.
    cell_report_t seen;
    cell_report_t want;

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen.read_value        = rsp_ch.read_value;
            seen.cell_active       = rsp_ch.cell_active;
            seen.status            = rsp_ch.status;
            seen.tile_present      = rsp_ch.tile_present;
            seen.tile_active_cells = rsp_ch.tile_active_cells;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("response beat with nothing pending: %p", seen);
            end else begin
                want = pending_reports.pop_front();
                if (seen.read_value !== want.read_value
                    || seen.cell_active !== want.cell_active
                    || seen.status !== want.status
                    || seen.tile_present !== want.tile_present
                    || seen.tile_active_cells !== want.tile_active_cells) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"mismatch (exp/got): value %h/%h active %b/%b ",
                                  "status %0d/%0d present %b/%b count %0d/%0d"},
                                 want.read_value, seen.read_value,
                                 want.cell_active, seen.cell_active,
                                 want.status, seen.status,
                                 want.tile_present, seen.tile_present,
                                 want.tile_active_cells, seen.tile_active_cells);
                end
            end
        end
    end

    // Watchdog: too long with no beat on either channel means a hang.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/stgs_pkg.sv
rtl/stgs_req_if.sv
rtl/stgs_rsp_if.sv
rtl/stgs_ram.sv
rtl/stgs_pool.sv
rtl/sparse_tiled_grid_store.sv
test/sparse_tiled_grid_store_tb.sv
